@@ rtl/core/dhoat_pkg.sv @@
// Shared types and constants for the double hash open address table.
package dhoat_pkg;

    localparam logic [6:0] SIZE_RESET = 7'd17;
    localparam int unsigned MULT_START = 53;
    localparam int unsigned MULT_BASE  = 31;

    typedef enum logic [1:0] {
        OP_SEARCH = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MARK_FREE = 2'd0,
        MARK_LIVE = 2'd1,
        MARK_TOMB = 2'd2,
        MARK_RSVD = 2'd3
    } mark_t;

    typedef enum logic [2:0] {
        ST_FOUND    = 3'd0,
        ST_MISS     = 3'd1,
        ST_INSERTED = 3'd2,
        ST_UPDATED  = 3'd3,
        ST_REMOVED  = 3'd4,
        ST_FULL     = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_HASH,
        S_STEP,
        S_PROBE,
        S_CHECK,
        S_WRITE,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        H_IDLE,
        H_INIT,
        H_BYTE,
        H_SUM
    } hash_state_t;

endpackage

@@ rtl/core/dhoat_hash.sv @@
// Sequential hash unit: bit-serial modular arithmetic for first hash and probe step.
module dhoat_hash
    import dhoat_pkg::*;
#(
    parameter int KEY_BYTES = 8,
    parameter int IW        = 6
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [8*KEY_BYTES-1:0] key,
    input  logic [3:0]             len,
    input  logic [IW:0]            m,
    output logic                   done,
    output logic [IW-1:0]          h1,
    output logic [IW-1:0]          h2
);

    localparam int SW = 12;
    localparam logic [7:0] START_BITS = 8'(MULT_START);
    localparam logic [7:0] BASE_BITS  = 8'(MULT_BASE);

    hash_state_t    ph_reg, ph_next;
    logic [3:0]     idx_reg, idx_next;
    logic [3:0]     bc_reg, bc_next;
    logic [IW:0]    h_reg, h_next;
    logic [IW:0]    p_reg, p_next;
    logic [IW:0]    a_reg, a_next;
    logic [IW:0]    q_reg, q_next;
    logic [SW-1:0]  s_reg, s_next;
    logic [IW-1:0]  h2_reg, h2_next;
    logic           done_reg, done_next;
    logic [7:0]     kb;
    logic [IW:0]    m1;
    logic [IW:0]    a_dbl, a_add, q_dbl, q_add, h_sum, i_step, r_step;

    // x < 2*mm assumed: one compare and subtract
    function automatic logic [IW:0] fold(input logic [IW+1:0] x, input logic [IW:0] mm);
        logic [IW+1:0] mx;
        mx = (IW+2)'(mm);
        return (x >= mx) ? (IW+1)'(x - mx) : (IW+1)'(x);
    endfunction

    always_comb
    begin
        kb     = key[8*idx_reg[2:0] +: 8];
        m1     = m - 1'b1;
        a_dbl  = fold({a_reg, 1'b0}, m);
        q_dbl  = fold({q_reg, 1'b0}, m);
        a_add  = fold((IW+2)'(a_dbl) + (IW+2)'(kb[bc_reg[2:0]] ? p_reg : '0), m);
        q_add  = fold((IW+2)'(q_dbl) + (IW+2)'(BASE_BITS[bc_reg[2:0]] ? p_reg : '0), m);
        h_sum  = fold((IW+2)'(h_reg) + (IW+2)'(a_add), m);
        i_step = fold({a_reg, START_BITS[bc_reg[2:0]]}, m);
        r_step = fold({a_reg, s_reg[bc_reg]}, m1);
    end

    always_comb
    begin
        ph_next = ph_reg;
        case (ph_reg)
            H_IDLE:  if (start) ph_next = H_INIT;
            H_INIT:  if (bc_reg == 4'd0) ph_next = H_BYTE;
            H_BYTE:  if (bc_reg == 4'd0 && idx_reg + 1'b1 == len) ph_next = H_SUM;
            H_SUM:   if (bc_reg == 4'd0) ph_next = H_IDLE;
            default: ph_next = H_IDLE;
        endcase
    end

    always_comb
    begin
        idx_next  = idx_reg;
        bc_next   = bc_reg;
        h_next    = h_reg;
        p_next    = p_reg;
        a_next    = a_reg;
        q_next    = q_reg;
        s_next    = s_reg;
        h2_next   = h2_reg;
        done_next = 1'b0;
        case (ph_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    idx_next = '0;
                    bc_next  = 4'd7;
                    h_next   = '0;
                    a_next   = '0;
                    s_next   = '0;
                end
            end
            H_INIT:
            begin
                a_next  = i_step;
                bc_next = bc_reg - 1'b1;
                if (bc_reg == 4'd0)
                begin
                    p_next  = i_step;
                    a_next  = '0;
                    q_next  = '0;
                    bc_next = 4'd7;
                end
            end
            H_BYTE:
            begin
                a_next  = a_add;
                q_next  = q_add;
                bc_next = bc_reg - 1'b1;
                if (bc_reg == 4'd0)
                begin
                    h_next   = h_sum;
                    p_next   = q_add;
                    s_next   = s_reg + SW'(kb);
                    idx_next = idx_reg + 1'b1;
                    a_next   = '0;
                    q_next   = '0;
                    bc_next  = 4'd7;
                    if (idx_reg + 1'b1 == len) bc_next = 4'(SW-1);
                end
            end
            H_SUM:
            begin
                a_next  = r_step;
                bc_next = bc_reg - 1'b1;
                if (bc_reg == 4'd0)
                begin
                    h2_next   = IW'(r_step + 1'b1);
                    done_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= H_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        bc_reg  <= bc_next;
        h_reg   <= h_next;
        p_reg   <= p_next;
        a_reg   <= a_next;
        q_reg   <= q_next;
        s_reg   <= s_next;
        h2_reg  <= h2_next;
    end

    assign done = done_reg;
    assign h1   = h_reg[IW-1:0];
    assign h2   = h2_reg;

endmodule

@@ rtl/core/double_hash_open_address_table.sv @@
// Operation: bit-serial hashing and setup over the key bytes, then S_PROBE, S_CHECK per probe.
// Flow: one request at a time, with a new request stalled until the last result
// is taken; the time per request is set by hashing and the probe loop over the
// slot memory.
// Reset: clears control, live count and table size (17), then sweeps all slot marks
// to never used while no request is taken.
module double_hash_open_address_table
    import dhoat_pkg::*;
#(
    parameter int MAX_SLOTS  = 64,
    parameter int KEY_BYTES  = 8,
    parameter int VALUE_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [31:0] key_low,
    input  logic [31:0] key_high,
    input  logic [3:0]  key_length,
    input  logic [31:0] value_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] value_out,
    output logic [5:0]  slot,
    output logic [6:0]  occupancy,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  table_size
);

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int KW = 8*KEY_BYTES;
    localparam int EW = 2 + KW + 4 + VALUE_BITS;

    state_t state_reg, state_next;
    logic [6:0]      size_reg;
    logic [IW:0]     m_reg;
    logic [1:0]      op_reg;
    logic [KW-1:0]   key_reg;
    logic [3:0]      len_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [IW:0]     t_reg, t_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [IW-1:0]   h1_reg, h2_reg;
    logic            hit_reg, hit_next, hf_reg, hf_next;
    logic [IW-1:0]   hit_idx_reg, hit_idx_next, free_idx_reg, free_idx_next;
    logic [VALUE_BITS-1:0] hit_val_reg, hit_val_next;
    logic [IW-1:0]   clr_reg;
    logic [6:0]      live_reg, live_next;
    logic            ov_reg;
    logic [2:0]      st_reg;
    logic [31:0]     vo_reg;
    logic [5:0]      sl_reg;

    logic [EW-1:0] mem [MAX_SLOTS];
    logic [EW-1:0] rd_reg;
    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [EW-1:0] wdata;

    logic [63:0]   key_full;
    logic [KW-1:0] key_m;
    logic [3:0]    len_c;
    logic          hs, hdone;
    logic [IW-1:0] h1w, h2w;
    logic [IW:0]   msz;
    logic [IW+1:0] nsum;
    mark_t         rmark;
    logic [KW-1:0] rkey;
    logic [3:0]    rlen;
    logic [VALUE_BITS-1:0] rval;
    logic          accept;

    assign key_full = {key_high, key_low};
    always_comb
    begin
        len_c = key_length;
        if (len_c == 4'd0) len_c = 4'd1;
        if (len_c > 4'(KEY_BYTES)) len_c = 4'(KEY_BYTES);
        for (int b = 0; b < KEY_BYTES; b++)
            key_m[8*b +: 8] = (b < len_c) ? key_full[8*b +: 8] : 8'd0;
        msz = (IW+1)'(size_reg);
        if (size_reg < 7'd2) msz = (IW+1)'(2);
        else if ({25'd0, size_reg} > MAX_SLOTS) msz = (IW+1)'(MAX_SLOTS);
    end

    assign in_stall  = (state_reg != S_IDLE) || ov_reg;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    dhoat_hash #(.KEY_BYTES(KEY_BYTES), .IW(IW)) u_hash (
        .clk(clk), .rst_n(rst_n), .start(hs), .key(key_reg), .len(len_reg),
        .m(m_reg), .done(hdone), .h1(h1w), .h2(h2w)
    );
    assign hs = (state_reg == S_HASH) && t_reg == '0;

    assign rmark = mark_t'(rd_reg[EW-1 -: 2]);
    assign rkey  = rd_reg[EW-3 -: KW];
    assign rlen  = rd_reg[VALUE_BITS +: 4];
    assign rval  = rd_reg[VALUE_BITS-1:0];
    assign nsum  = (IW+2)'(idx_reg) + (IW+2)'(h2_reg);

    always_comb
    begin
        state_next    = state_reg;
        t_next        = t_reg;
        idx_next      = idx_reg;
        hit_next      = hit_reg;
        hf_next       = hf_reg;
        hit_idx_next  = hit_idx_reg;
        free_idx_next = free_idx_reg;
        hit_val_next  = hit_val_reg;
        case (state_reg)
            S_CLEAR: if (clr_reg == IW'(MAX_SLOTS-1)) state_next = S_IDLE;
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_HASH;
                    t_next     = '0;
                end
            end
            S_HASH:
            begin
                t_next = (IW+1)'(1);
                if (hdone) state_next = S_STEP;
            end
            S_STEP:
            begin
                t_next   = '0;
                idx_next = h1_reg;
                hit_next = 1'b0;
                hf_next  = 1'b0;
                state_next = S_PROBE;
            end
            S_PROBE: state_next = S_CHECK;
            S_CHECK:
            begin
                state_next = S_PROBE;
                if (rmark == MARK_FREE)
                begin
                    if (!hf_reg)
                    begin
                        hf_next = 1'b1;
                        free_idx_next = idx_reg;
                    end
                    state_next = S_WRITE;
                end
                else if (rmark == MARK_LIVE)
                begin
                    if (rlen == len_reg && rkey == key_reg)
                    begin
                        hit_next = 1'b1;
                        hit_idx_next = idx_reg;
                        hit_val_next = rval;
                        state_next = S_WRITE;
                    end
                end
                else if (!hf_reg)
                begin
                    hf_next = 1'b1;
                    free_idx_next = idx_reg;
                end
                if (state_next == S_PROBE)
                begin
                    t_next = t_reg + 1'b1;
                    idx_next = (nsum >= (IW+2)'(m_reg)) ? IW'(nsum - (IW+2)'(m_reg))
                                                        : IW'(nsum);
                    if (t_reg + 1'b1 == m_reg) state_next = S_WRITE;
                end
            end
            S_WRITE: state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg;
        wdata = rd_reg;
        raddr = idx_reg;
        live_next = live_reg;
        if (state_reg == S_CLEAR)
        begin
            we    = 1'b1;
            waddr = clr_reg;
            wdata = '0;
        end
        else if (state_reg == S_WRITE)
        begin
            if (op_reg == OP_INSERT && hit_reg)
            begin
                we = 1'b1;
                waddr = hit_idx_reg;
                wdata = {MARK_LIVE, key_reg, len_reg, val_reg};
            end
            else if (op_reg == OP_INSERT && hf_reg)
            begin
                we = 1'b1;
                waddr = free_idx_reg;
                wdata = {MARK_LIVE, key_reg, len_reg, val_reg};
                live_next = live_reg + 1'b1;
            end
            else if (op_reg == OP_REMOVE && hit_reg)
            begin
                we = 1'b1;
                waddr = hit_idx_reg;
                wdata = {MARK_TOMB, key_reg, len_reg, hit_val_reg};
                live_next = live_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we) mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            size_reg  <= SIZE_RESET;
            live_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            live_reg  <= live_next;
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (cfg_valid) size_reg <= table_size;
            if (ov_reg && !out_stall) ov_reg <= 1'b0;
            else if (state_reg == S_WRITE) ov_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        idx_reg      <= idx_next;
        hit_reg      <= hit_next;
        hf_reg       <= hf_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        hit_val_reg  <= hit_val_next;
        if (hdone)
        begin
            h1_reg <= h1w;
            h2_reg <= h2w;
        end
        if (accept)
        begin
            op_reg  <= op;
            key_reg <= key_m;
            len_reg <= len_c;
            val_reg <= VALUE_BITS'(value_in);
            m_reg   <= msz;
        end
        if (state_reg == S_WRITE)
        begin
            st_reg <= ST_MISS;
            vo_reg <= '0;
            sl_reg <= '0;
            case (op_reg)
                OP_SEARCH:
                    if (hit_reg)
                    begin
                        st_reg <= ST_FOUND;
                        vo_reg <= 32'(hit_val_reg);
                        sl_reg <= 6'(hit_idx_reg);
                    end
                OP_INSERT:
                    if (hit_reg)
                    begin
                        st_reg <= ST_UPDATED;
                        sl_reg <= 6'(hit_idx_reg);
                    end
                    else if (hf_reg)
                    begin
                        st_reg <= ST_INSERTED;
                        sl_reg <= 6'(free_idx_reg);
                    end
                    else st_reg <= ST_FULL;
                OP_REMOVE:
                    if (hit_reg)
                    begin
                        st_reg <= ST_REMOVED;
                        sl_reg <= 6'(hit_idx_reg);
                    end
                default: st_reg <= ST_MISS;
            endcase
        end
    end

    assign out_valid = ov_reg;
    assign status    = st_reg;
    assign value_out = vo_reg;
    assign slot      = sl_reg;
    assign occupancy = live_reg;

endmodule
